// File: rtl/multiplexed_clock_digit_driver_macros.svh
// Assertion macros for the multiplexed clock digit driver.
// Used by the RTL files that carry concurrent checks; needs nothing else.
`ifndef MULTIPLEXED_CLOCK_DIGIT_DRIVER_MACROS_SVH
`define MULTIPLEXED_CLOCK_DIGIT_DRIVER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define MCDD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MCDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCDD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/mcdd_pkg.sv
// Package for the multiplexed clock digit driver: types, limits, segment table.
// No dependencies; imported by mcdd_decode and the top level.
`default_nettype none

package mcdd_pkg;

  localparam int NUM_DIGITS_DEF = 6;   // default scan length
  localparam int NUM_SHOWN      = 6;   // positions that carry a time digit

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  localparam logic [7:0] SEG_BLANK = 8'hFF;

  typedef logic [2:0] pos_t;
  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;
  typedef logic [5:0] enable_t;

  typedef struct packed {
    seg_t    seg;
    enable_t enable;
    pos_t    pos;
  } result_t;

  // Tens digit of a value 0..63 via multiply by 13 and shift by 7.
  function automatic digit_t tens_of(input logic [5:0] v);
    logic [9:0] prod;
    prod = 10'(v) * 10'd13;
    return digit_t'(prod[9:7]);
  endfunction

  function automatic digit_t ones_of(input logic [5:0] v);
    logic [5:0] t;
    t = 6'(tens_of(v)) * 6'd10;
    return digit_t'(v - t);
  endfunction

  // Active-low segment patterns, bit 0 is the decimal point (lit for all digits but 1 and 2).
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'h80;
      4'd1:    s = 8'hF3;
      4'd2:    s = 8'h49;
      4'd3:    s = 8'h60;
      4'd4:    s = 8'h32;
      4'd5:    s = 8'h24;
      4'd6:    s = 8'h04;
      4'd7:    s = 8'hF0;
      4'd8:    s = 8'h00;
      4'd9:    s = 8'h30;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mcdd_decode.sv
// Digit decode: clamps the time, picks the digit at a scan position, builds
// the segment byte and digit select. Depends on mcdd_pkg.
`default_nettype none

module mcdd_decode (
  input  wire logic [4:0]      hour,
  input  wire logic [5:0]      minute,
  input  wire logic [5:0]      second,
  input  wire mcdd_pkg::pos_t  pos,
  output mcdd_pkg::result_t    res
);
  import mcdd_pkg::*;

  logic [5:0] h_c, m_c, s_c;
  digit_t     digit;
  logic       have_digit;

  always_comb begin
    h_c = (hour > HOUR_MAX) ? 6'(HOUR_MAX) : 6'(hour);
    m_c = (minute > MINSEC_MAX) ? MINSEC_MAX : minute;
    s_c = (second > MINSEC_MAX) ? MINSEC_MAX : second;

    have_digit = 1'b1;
    unique case (pos)
      3'd0:    digit = ones_of(s_c);
      3'd1:    digit = tens_of(s_c);
      3'd2:    digit = ones_of(m_c);
      3'd3:    digit = tens_of(m_c);
      3'd4:    digit = ones_of(h_c);
      3'd5:    digit = tens_of(h_c);
      default: begin
        digit      = '0;
        have_digit = 1'b0;
      end
    endcase

    res.pos = pos;
    if (have_digit) begin
      res.seg    = seg_of(digit);
      res.enable = enable_t'(6'd1 << pos);
    end else begin
      res.seg    = SEG_BLANK;
      res.enable = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/multiplexed_clock_digit_driver.sv
// Multiplexed clock digit driver, top level.
// Depends on mcdd_pkg, mcdd_decode and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transaction per refresh tick,
//    carrying hour, minute and second in binary. Values above range are
//    clamped (hour to 23, minute and second to 59).
//  - Result channel (out_valid / out_stall): one transaction per input,
//    giving the active-low segment byte, the one-hot digit select and the
//    scan position shown. Position 0 is seconds ones, 5 is hours tens;
//    positions 6 and 7 (NUM_DIGITS above 6) show blank with no select.
//  - out_valid rises once an accepted transaction has passed the input register,
//    then the result register. One transaction per cycle while out_stall is low.
//  - The scan index is sampled and advanced when an input is accepted,
//    wrapping to 0 after position NUM_DIGITS-1.
//  - Reset (rst_n low, synchronous) clears the scan index and both valid
//    flags; no result is pending afterwards.
//  - When out_stall holds a result, the input register keeps one more
//    transaction; in_stall rises only when both stages are full.
`default_nettype none
`include "multiplexed_clock_digit_driver_macros.svh"

module multiplexed_clock_digit_driver #(
  parameter int NUM_DIGITS = mcdd_pkg::NUM_DIGITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] in_hour,
  input  wire logic [5:0] in_minute,
  input  wire logic [5:0] in_second,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_segment_pattern,
  output logic [5:0]      out_digit_enable,
  output logic [2:0]      out_digit_position
);
  import mcdd_pkg::*;

  localparam pos_t LAST_POS = pos_t'(NUM_DIGITS - 1);

  // Scan state
  pos_t scan_index_r, scan_index_nxt;

  // Input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [4:0] s1_hour_r;
  logic [5:0] s1_minute_r, s1_second_r;
  pos_t       s1_pos_r;

  // Result register stage
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t dec_res;

  logic out_hold;   // result held by receiver
  logic s1_adv;     // input stage may take a new transaction
  logic in_acc;

  assign out_hold = out_valid_r && out_stall;
  assign s1_adv   = !s1_valid_r || !out_hold;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  always_comb begin
    scan_index_nxt = scan_index_r;
    if (in_acc) begin
      scan_index_nxt = (scan_index_r >= LAST_POS) ? '0 : scan_index_r + 3'd1;
    end
    s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
    out_valid_nxt = out_hold ? out_valid_r : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_index_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_index_r <= scan_index_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
      s1_second_r <= in_second;
      s1_pos_r    <= scan_index_r;
    end
    if (!out_hold && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  mcdd_decode u_decode (
    .hour   (s1_hour_r),
    .minute (s1_minute_r),
    .second (s1_second_r),
    .pos    (s1_pos_r),
    .res    (dec_res)
  );

  assign out_valid           = out_valid_r;
  assign out_segment_pattern = out_res_r.seg;
  assign out_digit_enable    = out_res_r.enable;
  assign out_digit_position  = out_res_r.pos;

  `MCDD_ASSERT(a_scan_range, clk, rst_n, scan_index_r <= LAST_POS, "scan index beyond last digit")
  `MCDD_ASSERT(a_scan_step, clk, rst_n, (in_acc && scan_index_r != LAST_POS) |=> (scan_index_r == $past(scan_index_r) + 3'd1), "scan index did not advance")
  `MCDD_ASSERT(a_s1_keep, clk, rst_n, (s1_valid_r && out_hold) |=> s1_valid_r, "input stage dropped a transaction")
  `MCDD_ASSERT(a_sel_onehot, clk, rst_n, out_valid_r |-> $onehot0(out_digit_enable), "digit select not one-hot")
  `MCDD_ASSERT(a_sel_match, clk, rst_n, out_valid_r |-> ((out_digit_enable != 6'd0) == (out_digit_position < 3'(NUM_SHOWN))), "digit select disagrees with position")
  `MCDD_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> (!out_valid_r && !s1_valid_r), "valid set after reset")

endmodule

`default_nettype wire

// File: dv/tb_multiplexed_clock_digit_driver.sv
// Testbench for multiplexed_clock_digit_driver: directed and random refresh ticks,
// checked against an in-bench scan predictor. Needs mcdd_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_multiplexed_clock_digit_driver;
  import mcdd_pkg::*;

  // Scan length of the instance; the predictor follows the same value.
  localparam int NUM_POS      = NUM_DIGITS_DEF;
  // Cycles without any transaction on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  // Two register stages, plus some margin, after the last result.
  localparam int DRAIN_CYCLES = 6;

  // Active-low glyphs for digits 9 down to 0, bit 0 is the decimal point (lit but for 1 and 2).
  localparam logic [9:0][7:0] GLYPHS = {
    8'h30, 8'h00, 8'hF0, 8'h04, 8'h24, 8'h32, 8'h60, 8'h49, 8'hF3, 8'h80
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [4:0] in_hour    = '0;
  logic [5:0] in_minute  = '0;
  logic [5:0] in_second  = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_segment_pattern;
  logic [5:0] out_digit_enable;
  logic [2:0] out_digit_position;

  // Predictor state: the scan position the next accepted tick will show.
  pos_t    model_scan_pos = '0;
  // Expected results, oldest first.
  result_t pending_glyphs[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit backpressure_on = 1'b1;  // receiver stall bursts enabled
  bit send_gaps_on    = 1'b1;  // sender idle bursts enabled

  multiplexed_clock_digit_driver #(
    .NUM_DIGITS(NUM_POS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_second          (in_second),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segment_pattern(out_segment_pattern),
    .out_digit_enable   (out_digit_enable),
    .out_digit_position (out_digit_position)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: clamp the time, pick the digit at the current scan position,
  // decode it, then advance the scan with wrap at the last position.
  // ---------------------------------------------------------------------------
  function automatic result_t predict_scan_digit(input logic [4:0] h,
                                                 input logic [5:0] m,
                                                 input logic [5:0] s);
    logic [4:0]  hc;
    logic [5:0]  mc;
    logic [5:0]  sc;
    int unsigned digit;
    bit          shown;
    result_t     r;
    hc = (h > HOUR_MAX) ? HOUR_MAX : h;
    mc = (m > MINSEC_MAX) ? MINSEC_MAX : m;
    sc = (s > MINSEC_MAX) ? MINSEC_MAX : s;
    shown = 1'b1;
    digit = 0;
    case (model_scan_pos)
      3'd0: digit = sc % 10;   // seconds ones
      3'd1: digit = sc / 10;   // seconds tens
      3'd2: digit = mc % 10;
      3'd3: digit = mc / 10;
      3'd4: digit = hc % 10;
      3'd5: digit = hc / 10;   // hours tens
      default: shown = 1'b0;   // no digit behind this position
    endcase
    r.pos = model_scan_pos;
    if (shown) begin
      r.seg    = GLYPHS[digit];
      r.enable = enable_t'(6'd1 << model_scan_pos);
    end else begin
      r.seg    = SEG_BLANK;
      r.enable = '0;
    end
    if (int'(model_scan_pos) >= NUM_POS - 1) begin
      model_scan_pos = '0;
    end else begin
      model_scan_pos = model_scan_pos + 3'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: present one refresh tick and hold it until the transaction is
  // accepted. Valid stays high across back-to-back ticks; it is only lowered
  // for an idle burst or after the last tick.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [4:0] h, input logic [5:0] m,
                           input logic [5:0] s);
    in_valid  <= 1'b1;
    in_hour   <= h;
    in_minute <= m;
    in_second <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_glyphs.push_back(predict_scan_digit(h, m, s));
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Receiver back-pressure: random bursts of stalled cycles.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (backpressure_on && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_glyphs.size() == 0) begin
        report_mismatch("unexpected result, position", 0, out_digit_position);
      end else begin
        want = pending_glyphs.pop_front();
        if (out_segment_pattern !== want.seg)
          report_mismatch("segment_pattern", want.seg, out_segment_pattern);
        if (out_digit_enable !== want.enable)
          report_mismatch("digit_enable", want.enable, out_digit_enable);
        if (out_digit_position !== want.pos)
          report_mismatch("digit_position", want.pos, out_digit_position);
      end
    end
  end

  // Activity tracking for the hang watchdog.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each time value is held for a full scan so every position sees it:
  // all zeros, the range maximum, just above range, and the field maxima.
  task automatic test_directed_extremes();
    repeat (6) send_tick(5'd0, 6'd0, 6'd0);
    repeat (6) send_tick(5'd23, 6'd59, 6'd59);
    repeat (6) send_tick(5'd24, 6'd60, 6'd60);   // clamp boundary
    repeat (6) send_tick(5'd31, 6'd63, 6'd63);   // all bits set
  endtask

  // A running clock: time moves on by a second on some ticks, with
  // rollovers at minute, hour and midnight, and a few out-of-range ticks.
  task automatic test_random_clock();
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    for (int seg = 0; seg < 5; seg++) begin
      if (seg % 2 == 0) begin
        h = 5'd23;
        m = 6'd59;
        s = 6'($urandom_range(30, 59));   // close to midnight
      end else begin
        h = 5'($urandom_range(0, 23));
        m = 6'($urandom_range(0, 59));
        s = 6'($urandom_range(0, 59));
      end
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(5'($urandom_range(24, 31)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(60, 63)));
        end else begin
          send_tick(h, m, s);
        end
        if ($urandom_range(0, 1) == 0) begin
          s = s + 6'd1;
          if (s == 6'd60) begin
            s = '0;
            m = m + 6'd1;
            if (m == 6'd60) begin
              m = '0;
              h = (h == 5'd23) ? 5'd0 : h + 5'd1;
            end
          end
        end
      end
    end
  endtask

  // Unconstrained fields over their full widths.
  task automatic test_full_width_fields();
    repeat (130) begin
      send_tick(5'($urandom()), 6'($urandom()), 6'($urandom()));
    end
  endtask

  // Last part: no idling on either side, one transaction per cycle.
  task automatic test_back_to_back();
    send_gaps_on = 1'b0;
    backpressure_on <= 1'b0;
    repeat (100) begin
      send_tick(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_clock();
    test_full_width_fields();
    test_back_to_back();

    // Same step as the last accept; nothing else drives valid here.
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_glyphs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
